// ===== hdl/dmvn_pkg.sv =====
// Shared types for the deformed mesh vertex normal block.
// Holds the controller-to-datapath command and status structs and their codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmvn_pkg;

  // Item kinds carried in tuser of the input channel
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_code_t;

  // Datapath actions, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_LD_FIN,
    OP_LD_WR,
    OP_RD_CAP,
    OP_TRI_CAP,
    OP_EDGE,
    OP_CROSS_SET,
    OP_CROSS_SUB,
    OP_MAG,
    OP_NORM,
    OP_SQ_FIN,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_LAST,
    OP_ACC_WR,
    OP_SET_DEGEN,
    OP_PUBLISH
  } dp_op_t;

  // Operand source of the shared multiplier
  typedef enum logic [1:0] {
    MS_LOAD,
    MS_CROSS,
    MS_SQ
  } mul_src_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] sel;     // component or corner the action works on
    mul_src_t   msrc;
    logic [2:0] msel;    // operand pair for the multiplier
    logic       rd_idx;  // read address from the vertex index, else from a corner
    logic [1:0] rsel;    // corner used as read address
  } dp_cmd_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      idx_ok;
    logic      tri_ok;
    logic      m_zero;
    logic      m_hi;
    logic      m_lo;
  } dp_sts_t;

  localparam logic [23:0] SCALE_RESET = 24'd655360;

endpackage

`default_nettype wire

// ===== hdl/dmvn_dp.sv =====
// Datapath: vertex stores, shared multiplier, square root and divider steps.
// Executes one dp_cmd_t per cycle from dmvn_ctrl; depends on dmvn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmvn_dp import dmvn_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [231:0]   in_tdata,
  input  wire logic [1:0]     in_tuser,
  input  wire logic           cfg_wr_en,
  input  wire logic [23:0]    cfg_wr_data,
  input  wire dp_cmd_t        cmd,
  input  wire logic [AW-1:0]  clr_addr,
  output dp_sts_t             sts,
  output logic [191:0]        out_tdata,
  output logic [0:0]          out_tuser
);

  localparam logic [31:0] MaxV = 32'(MAX_VERTICES);

  function automatic logic [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) sat32 = 32'h7FFF_FFFF;
    else if (v < -43'sd2147483648) sat32 = 32'h8000_0000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] d);
    mag33 = d[32] ? 33'(-d) : 33'(d);
  endfunction

  function automatic logic [31:0] red(input logic signed [32:0] d, input logic [1:0] k);
    logic [32:0] a;
    a = mag33(d) >> k;
    red = d[32] ? -a[31:0] : a[31:0];
  endfunction

  logic [23:0]        scale_r;
  cmd_code_t          cmd_r;
  logic [9:0]         idx_r;
  logic [31:0]        rest_r [3];
  logic [31:0]        disp_r [3];
  logic [9:0]         corner_r [3];
  logic [31:0]        ld_r [3];
  logic [31:0]        p_r [3][3];
  logic [31:0]        e1_r [3];
  logic [31:0]        e2_r [3];
  logic [63:0]        cr_r [3];
  logic [62:0]        mg_r [3];
  logic               neg_r [3];
  logic [62:0]        m_r;
  logic [61:0]        sum_r;
  logic [61:0]        x_r;
  logic [62:0]        res_r;
  logic [62:0]        bit_r;
  logic [31:0]        rem_r;
  logic [16:0]        nq_r;
  logic [31:0]        n_r [3];
  logic               res_status_r;
  logic [31:0]        res_pos_r [3];
  logic [31:0]        res_nrm_r [3];
  logic [191:0]       out_tdata_r;
  logic               out_status_r;
  logic signed [65:0] prod_r;
  logic [31:0]        rd_pos [3];
  logic [31:0]        rd_nrm [3];

  logic signed [32:0] ma, mb;
  logic [AW-1:0]      raddr;
  logic               pos_we, nrm_we;
  logic [AW-1:0]      pos_waddr, nrm_waddr;
  logic [31:0]        nrm_wdata [3];
  logic [31:0]        e1c [3], e2c [3];
  logic [32:0]        or1, or2;
  logic [62:0]        mgc [3];
  logic [63:0]        sq_t;
  logic               sq_ge;
  logic [30:0]        len;
  logic [31:0]        dvs;
  logic [46:0]        num;
  logic [32:0]        dv_t;
  logic               dv_ge;
  logic [31:0]        rem_nxt;
  logic [16:0]        nq_nxt;
  logic signed [57:0] ld_s;
  logic signed [42:0] ld_tot;

  // Status toward the controller
  always_comb begin
    sts.cmd    = cmd_r;
    sts.idx_ok = 32'(idx_r) < MaxV;
    sts.tri_ok = (32'(corner_r[0]) < MaxV) && (32'(corner_r[1]) < MaxV)
                 && (32'(corner_r[2]) < MaxV);
    sts.m_zero = (m_r == '0);
    sts.m_hi   = (m_r[62:30] != '0);
    sts.m_lo   = (m_r[62:29] == '0);
  end

  // Multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.msrc)
      MS_LOAD: begin
        ma = $signed({disp_r[cmd.msel[1:0]][31], disp_r[cmd.msel[1:0]]});
        mb = $signed({9'd0, scale_r});
      end
      MS_CROSS: begin
        unique case (cmd.msel)
          3'd0: begin ma = $signed({e1_r[1][31], e1_r[1]}); mb = $signed({e2_r[2][31], e2_r[2]}); end
          3'd1: begin ma = $signed({e1_r[2][31], e1_r[2]}); mb = $signed({e2_r[1][31], e2_r[1]}); end
          3'd2: begin ma = $signed({e1_r[2][31], e1_r[2]}); mb = $signed({e2_r[0][31], e2_r[0]}); end
          3'd3: begin ma = $signed({e1_r[0][31], e1_r[0]}); mb = $signed({e2_r[2][31], e2_r[2]}); end
          3'd4: begin ma = $signed({e1_r[0][31], e1_r[0]}); mb = $signed({e2_r[1][31], e2_r[1]}); end
          3'd5: begin ma = $signed({e1_r[1][31], e1_r[1]}); mb = $signed({e2_r[0][31], e2_r[0]}); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      MS_SQ: begin
        ma = $signed({3'd0, mg_r[cmd.msel[1:0]][29:0]});
        mb = ma;
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Product register
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  // Edge reduction: OR of magnitudes has the same leading bit as their max
  always_comb begin
    logic signed [32:0] d1 [3];
    logic signed [32:0] d2 [3];
    logic [1:0] k1, k2;
    or1 = '0;
    or2 = '0;
    for (int i = 0; i < 3; i++) begin
      d1[i] = $signed({p_r[1][i][31], p_r[1][i]}) - $signed({p_r[0][i][31], p_r[0][i]});
      d2[i] = $signed({p_r[2][i][31], p_r[2][i]}) - $signed({p_r[0][i][31], p_r[0][i]});
      or1 = or1 | mag33(d1[i]);
      or2 = or2 | mag33(d2[i]);
    end
    k1 = or1[32] ? 2'd2 : (or1[31] ? 2'd1 : 2'd0);
    k2 = or2[32] ? 2'd2 : (or2[31] ? 2'd1 : 2'd0);
    for (int i = 0; i < 3; i++) begin
      e1c[i] = red(d1[i], k1);
      e2c[i] = red(d2[i], k2);
    end
  end

  // Cross magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mgc[i] = cr_r[i][63] ? 63'(-cr_r[i]) : cr_r[i][62:0];
    end
  end

  // Square root step
  assign sq_t  = {1'b0, res_r} + {1'b0, bit_r};
  assign sq_ge = {2'b0, x_r} >= sq_t;
  assign len   = res_r[30:0];

  // Divider step: rounded quotient of (mg * 2^16 + len) / (2 * len)
  assign dvs     = {len, 1'b0};
  assign num     = 47'({mg_r[cmd.sel][29:0], 16'd0}) + 47'(len);
  assign dv_t    = {rem_r, nq_r[16]};
  assign dv_ge   = dv_t >= {1'b0, dvs};
  assign rem_nxt = dv_ge ? 32'(dv_t - {1'b0, dvs}) : dv_t[31:0];
  assign nq_nxt  = {nq_r[15:0], dv_ge};

  // Load: round disp * scale to Q16.16, add rest, saturate
  assign ld_s   = $signed({prod_r[56], prod_r[56:0]}) + 58'sd32768;
  assign ld_tot = $signed({ld_s[57], ld_s[57:16]})
                  + $signed({{11{rest_r[cmd.sel][31]}}, rest_r[cmd.sel]});

  // Memory address and write control
  always_comb begin
    raddr     = cmd.rd_idx ? AW'(idx_r) : AW'(corner_r[cmd.rsel]);
    pos_we    = (cmd.op == OP_LD_WR);
    pos_waddr = AW'(idx_r);
    nrm_we    = 1'b0;
    nrm_waddr = AW'(idx_r);
    for (int i = 0; i < 3; i++) begin
      logic signed [32:0] s;
      s = $signed({rd_nrm[i][31], rd_nrm[i]}) + $signed({n_r[i][31], n_r[i]});
      nrm_wdata[i] = '0;
      if (cmd.op == OP_ACC_WR) nrm_wdata[i] = sat32($signed({{10{s[32]}}, s}));
    end
    unique case (cmd.op)
      OP_CLEAR: begin nrm_we = 1'b1; nrm_waddr = clr_addr; end
      OP_LD_WR: nrm_we = 1'b1;
      OP_ACC_WR: begin nrm_we = 1'b1; nrm_waddr = AW'(corner_r[cmd.sel]); end
      default: nrm_we = 1'b0;
    endcase
  end

  // Position and normal stores, one lane per axis
  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [31:0] pos_mem [MAX_VERTICES];
    logic [31:0] nrm_mem [MAX_VERTICES];

    always_ff @(posedge clk) begin
      if (pos_we) pos_mem[pos_waddr] <= ld_r[g];
      rd_pos[g] <= pos_mem[raddr];
    end

    always_ff @(posedge clk) begin
      if (nrm_we) nrm_mem[nrm_waddr] <= nrm_wdata[g];
      rd_nrm[g] <= nrm_mem[raddr];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        cmd_r        <= cmd_code_t'(in_tuser);
        idx_r        <= in_tdata[9:0];
        res_status_r <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          rest_r[i]    <= in_tdata[10 + 32*i +: 32];
          disp_r[i]    <= in_tdata[106 + 32*i +: 32];
          corner_r[i]  <= in_tdata[202 + 10*i +: 10];
          res_pos_r[i] <= '0;
          res_nrm_r[i] <= '0;
        end
      end
      OP_LD_FIN: ld_r[cmd.sel] <= sat32(ld_tot);
      OP_RD_CAP: begin
        for (int i = 0; i < 3; i++) begin
          res_pos_r[i] <= rd_pos[i];
          res_nrm_r[i] <= rd_nrm[i];
        end
      end
      OP_TRI_CAP: begin
        for (int i = 0; i < 3; i++) p_r[cmd.sel][i] <= rd_pos[i];
      end
      OP_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_r[i] <= e1c[i];
          e2_r[i] <= e2c[i];
        end
      end
      OP_CROSS_SET: cr_r[cmd.sel] <= prod_r[63:0];
      OP_CROSS_SUB: cr_r[cmd.sel] <= cr_r[cmd.sel] - prod_r[63:0];
      OP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mg_r[i]  <= mgc[i];
          neg_r[i] <= cr_r[i][63];
        end
        m_r <= mgc[0] | mgc[1] | mgc[2];
      end
      OP_NORM: begin
        if (m_r[62:30] != '0) begin
          m_r <= m_r >> 1;
          for (int i = 0; i < 3; i++) mg_r[i] <= mg_r[i] >> 1;
        end else begin
          m_r <= m_r << 1;
          for (int i = 0; i < 3; i++) mg_r[i] <= mg_r[i] << 1;
        end
      end
      OP_SQ_FIN: sum_r <= ((cmd.sel == 2'd0) ? 62'd0 : sum_r) + prod_r[61:0];
      OP_SQRT_INIT: begin
        x_r   <= sum_r;
        res_r <= '0;
        bit_r <= 63'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          x_r   <= x_r - sq_t[61:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DIV_INIT: begin
        rem_r <= 32'(num[46:17]);
        nq_r  <= num[16:0];
      end
      OP_DIV_STEP: begin
        rem_r <= rem_nxt;
        nq_r  <= nq_nxt;
      end
      OP_DIV_LAST: begin
        rem_r <= rem_nxt;
        nq_r  <= nq_nxt;
        n_r[cmd.sel] <= neg_r[cmd.sel] ? -32'(nq_nxt) : 32'(nq_nxt);
      end
      OP_SET_DEGEN: res_status_r <= 1'b1;
      OP_PUBLISH: begin
        out_status_r <= res_status_r;
        out_tdata_r  <= {res_nrm_r[2], res_nrm_r[1], res_nrm_r[0],
                         res_pos_r[2], res_pos_r[1], res_pos_r[0]};
      end
      default: ;
    endcase
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_status_r;

endmodule

`default_nettype wire

// ===== hdl/dmvn_ctrl.sv =====
// Controller: sequences clearing, load, read and triangle work in the datapath.
// Issues dp_cmd_t each cycle and owns both channel handshakes; depends on dmvn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmvn_ctrl import dmvn_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  localparam int AW = $clog2(MAX_VERTICES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire dp_sts_t       sts,
  output dp_cmd_t            cmd,
  output logic [AW-1:0]      clr_addr
);

  localparam int CW = (AW > 5) ? AW : 5;

  typedef enum logic [18:0] {
    S_CLEAR = 19'b0000000000000000001,
    S_IDLE  = 19'b0000000000000000010,
    S_DEC   = 19'b0000000000000000100,
    S_LOAD  = 19'b0000000000000001000,
    S_LDWR  = 19'b0000000000000010000,
    S_RDADR = 19'b0000000000000100000,
    S_RDCAP = 19'b0000000000001000000,
    S_TRD   = 19'b0000000000010000000,
    S_EDGE  = 19'b0000000000100000000,
    S_CROSS = 19'b0000000001000000000,
    S_MAG   = 19'b0000000010000000000,
    S_NORM  = 19'b0000000100000000000,
    S_SQ    = 19'b0000001000000000000,
    S_SQI   = 19'b0000010000000000000,
    S_SQRT  = 19'b0000100000000000000,
    S_DIV   = 19'b0001000000000000000,
    S_ARD   = 19'b0010000000000000000,
    S_AWR   = 19'b0100000000000000000,
    S_DONE  = 19'b1000000000000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    j_r, j_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] cm1;
  logic          publish;

  assign cm1      = cnt_r - CW'(1);
  assign clr_addr = cnt_r[AW-1:0];

  // Next state and command decode
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    j_nxt      = j_r;
    in_tready  = 1'b0;
    publish    = 1'b0;
    cmd.op     = OP_NONE;
    cmd.sel    = 2'd0;
    cmd.msrc   = MS_LOAD;
    cmd.msel   = 3'd0;
    cmd.rd_idx = 1'b0;
    cmd.rsel   = 2'd0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op  = OP_CLEAR;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(MAX_VERTICES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cnt_nxt = '0;
        unique case (sts.cmd)
          CMD_LOAD: state_nxt = sts.idx_ok ? S_LOAD : S_DONE;
          CMD_READ: state_nxt = sts.idx_ok ? S_RDADR : S_DONE;
          CMD_TRI: begin
            if (sts.tri_ok) begin
              state_nxt = S_TRD;
            end else begin
              cmd.op    = OP_SET_DEGEN;
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      // Scale the three displacements through the shared multiplier
      S_LOAD: begin
        cmd.msrc = MS_LOAD;
        cmd.msel = 3'(cnt_r);
        if (cnt_r != '0) begin
          cmd.op  = OP_LD_FIN;
          cmd.sel = 2'(cm1);
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(3)) state_nxt = S_LDWR;
      end
      S_LDWR: begin
        cmd.op    = OP_LD_WR;
        state_nxt = S_DONE;
      end
      S_RDADR: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_RDCAP;
      end
      S_RDCAP: begin
        cmd.op    = OP_RD_CAP;
        state_nxt = S_DONE;
      end
      // Fetch the three corner positions
      S_TRD: begin
        cmd.rsel = 2'(cnt_r);
        if (cnt_r != '0) begin
          cmd.op  = OP_TRI_CAP;
          cmd.sel = 2'(cm1);
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(3)) begin
          cnt_nxt   = '0;
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.op    = OP_EDGE;
        state_nxt = S_CROSS;
      end
      // Six partial products, paired into the three cross components
      S_CROSS: begin
        cmd.msrc = MS_CROSS;
        cmd.msel = 3'(cnt_r);
        if (cnt_r != '0) begin
          cmd.op  = cm1[0] ? OP_CROSS_SUB : OP_CROSS_SET;
          cmd.sel = 2'(cm1 >> 1);
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(6)) begin
          cnt_nxt   = '0;
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_NORM;
      end
      // Shift one bit a cycle until the largest magnitude sits in [2^29, 2^30)
      S_NORM: begin
        if (sts.m_zero) begin
          cmd.op    = OP_SET_DEGEN;
          state_nxt = S_DONE;
        end else if (sts.m_hi || sts.m_lo) begin
          cmd.op = OP_NORM;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.msrc = MS_SQ;
        cmd.msel = 3'(cnt_r);
        if (cnt_r != '0) begin
          cmd.op  = OP_SQ_FIN;
          cmd.sel = 2'(cm1);
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(3)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQI;
        end
      end
      S_SQI: begin
        cmd.op    = OP_SQRT_INIT;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT_STEP;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(31)) begin
          cnt_nxt   = '0;
          j_nxt     = 2'd0;
          state_nxt = S_DIV;
        end
      end
      // One quotient bit a cycle, 17 bits per component
      S_DIV: begin
        cmd.sel = j_r;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == '0) begin
          cmd.op = OP_DIV_INIT;
        end else if (cnt_r == CW'(17)) begin
          cmd.op  = OP_DIV_LAST;
          cnt_nxt = '0;
          j_nxt   = j_r + 2'd1;
          if (j_r == 2'd2) begin
            j_nxt     = 2'd0;
            state_nxt = S_ARD;
          end
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      // Read-modify-write of each corner's normal, in corner order
      S_ARD: begin
        cmd.rsel  = j_r;
        state_nxt = S_AWR;
      end
      S_AWR: begin
        cmd.op  = OP_ACC_WR;
        cmd.sel = j_r;
        j_nxt   = j_r + 2'd1;
        if (j_r == 2'd2) begin
          j_nxt     = 2'd0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ARD;
        end
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.op    = OP_PUBLISH;
          publish   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on publish, drop after transfer
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (publish) out_valid_nxt = 1'b1;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      j_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/deformed_mesh_vertex_normals.sv =====
// Deformed mesh vertex normal engine: vertex stores with per-vertex normals.
// Top level joining dmvn_ctrl and dmvn_dp; depends on dmvn_pkg.
//
// Usage:
//   Input channel in_*: tuser is the item kind (load, triangle, read). A load
//   stores rest + scale * disp and zeroes the vertex normal; a triangle adds
//   its half-unit face normal into its three corners; a read returns the
//   stored position and normal. Every item returns exactly one result on
//   out_*, with tuser set when a triangle was skipped (degenerate or a
//   corner out of range).
//   cfg_wr_en/cfg_wr_data write the displacement scale (unsigned Q8.16);
//   write it only while no item is in flight.
//   The triangle time is set by the one-bit normalize shifter, the 32-step
//   square root and three divides. One item is in work at a time; the next
//   is taken as soon as the result sits in the output register. After reset
//   the normal stores are swept to zero, one vertex a cycle, with in_tready
//   low. When the receiver stalls the result holds in the output register
//   and the block finishes the next item up to its publish step, then waits.
`timescale 1ns / 1ps
`default_nettype none

module deformed_mesh_vertex_normals import dmvn_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // vertex_index[9:0], rest_x, rest_y, rest_z, disp_x, disp_y, disp_z,
  // corner_a, corner_b, corner_c (from bit 0 up)
  input  wire logic [231:0] in_tdata,
  // cmd[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (from bit 0 up)
  output logic [191:0]      out_tdata,
  // status[0]
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_wr_en,
  input  wire logic [23:0]  cfg_wr_data
);

  localparam int AW = $clog2(MAX_VERTICES);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] clr_addr;

  dmvn_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .clr_addr   (clr_addr)
  );

  dmvn_dp #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .clr_addr    (clr_addr),
    .sts         (sts),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

`default_nettype wire

// ===== verif/dmvn_checker.sv =====
// Checker for deformed_mesh_vertex_normals: watches the stream and config ports,
// predicts every result from its own copy of the vertex stores, compares.
// Depends on dmvn_pkg for the item kind codes and the reset scale.
`timescale 1ns / 1ps

module dmvn_checker import dmvn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [231:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [191:0] out_tdata,
  input  logic [0:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [23:0]  cfg_wr_data,
  output int           mismatches,
  output int           pending
);

  typedef struct packed {
    logic         skipped;
    logic [191:0] fields;
  } mesh_result_t;

  localparam longint unsigned LIM31 = 64'h8000_0000;
  localparam longint unsigned LIM30 = 64'h4000_0000;
  localparam longint unsigned LIM29 = 64'h2000_0000;

  logic [23:0]        disp_scale;
  logic signed [31:0] pos_x_mem [1024];
  logic signed [31:0] pos_y_mem [1024];
  logic signed [31:0] pos_z_mem [1024];
  logic signed [31:0] nrm_x_mem [1024];
  logic signed [31:0] nrm_y_mem [1024];
  logic signed [31:0] nrm_z_mem [1024];
  mesh_result_t       awaited_results [$];
  int                 err_count;

  assign mismatches = err_count;
  assign pending    = awaited_results.size();

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // rest + scale * disp, product rounded half up at bit 16
  function automatic logic signed [31:0] deformed_coord(logic signed [31:0] rest,
                                                        logic signed [31:0] disp);
    longint sc;
    longint prod;
    sc = longint'({40'd0, disp_scale});
    prod = longint'(disp) * sc;
    return clamp32(longint'(rest) + ((prod + 64'sd32768) >>> 16));
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  // truncate an edge toward zero until every component fits below 2^31
  function automatic void shrink_edge(inout longint e0, inout longint e1, inout longint e2);
    longint unsigned m;
    int unsigned k;
    m = magnitude(e0);
    if (magnitude(e1) > m) m = magnitude(e1);
    if (magnitude(e2) > m) m = magnitude(e2);
    k = 0;
    while ((m >> k) >= LIM31) k++;
    e0 = e0 < 0 ? -longint'(magnitude(e0) >> k) : longint'(magnitude(e0) >> k);
    e1 = e1 < 0 ? -longint'(magnitude(e1) >> k) : longint'(magnitude(e1) >> k);
    e2 = e2 < 0 ? -longint'(magnitude(e2) >> k) : longint'(magnitude(e2) >> k);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic void add_face(int unsigned v, longint n[3]);
    nrm_x_mem[v] = clamp32(longint'(nrm_x_mem[v]) + n[0]);
    nrm_y_mem[v] = clamp32(longint'(nrm_y_mem[v]) + n[1]);
    nrm_z_mem[v] = clamp32(longint'(nrm_z_mem[v]) + n[2]);
  endfunction

  // returns 1 when the triangle is degenerate and skipped
  function automatic logic accumulate_face(int unsigned a, int unsigned b, int unsigned c);
    longint ax, ay, az, bx, by, bz;
    longint cr[3];
    longint nv[3];
    longint unsigned mg[3];
    longint unsigned m;
    longint unsigned len;
    longint unsigned q;
    ax = longint'(pos_x_mem[b]) - pos_x_mem[a];
    ay = longint'(pos_y_mem[b]) - pos_y_mem[a];
    az = longint'(pos_z_mem[b]) - pos_z_mem[a];
    bx = longint'(pos_x_mem[c]) - pos_x_mem[a];
    by = longint'(pos_y_mem[c]) - pos_y_mem[a];
    bz = longint'(pos_z_mem[c]) - pos_z_mem[a];
    shrink_edge(ax, ay, az);
    shrink_edge(bx, by, bz);
    cr[0] = ay * bz - az * by;
    cr[1] = az * bx - ax * bz;
    cr[2] = ax * by - ay * bx;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = magnitude(cr[i]);
      if (mg[i] > m) m = mg[i];
    end
    if (m == 0) return 1'b1;
    // normalize the largest magnitude into [2^29, 2^30)
    while (m >= LIM30) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mg[i] >>= 1;
    end
    while (m < LIM29) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
    end
    len = floor_sqrt(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 16) + len) / (len * 2);
      nv[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
    end
    add_face(a, nv);
    add_face(b, nv);
    add_face(c, nv);
    return 1'b0;
  endfunction

  function automatic mesh_result_t predict_result(logic [1:0] kind, logic [231:0] d);
    mesh_result_t r;
    int unsigned vi;
    vi = d[9:0];
    r = '0;
    case (cmd_code_t'(kind))
      CMD_LOAD: begin
        pos_x_mem[vi] = deformed_coord(d[41:10], d[137:106]);
        pos_y_mem[vi] = deformed_coord(d[73:42], d[169:138]);
        pos_z_mem[vi] = deformed_coord(d[105:74], d[201:170]);
        nrm_x_mem[vi] = 0;
        nrm_y_mem[vi] = 0;
        nrm_z_mem[vi] = 0;
      end
      CMD_TRI:  r.skipped = accumulate_face(d[211:202], d[221:212], d[231:222]);
      CMD_READ: r.fields = {nrm_z_mem[vi], nrm_y_mem[vi], nrm_x_mem[vi],
                            pos_z_mem[vi], pos_y_mem[vi], pos_x_mem[vi]};
      default: ;
    endcase
    return r;
  endfunction

  // compare results first, then record new expectations
  always @(posedge clk) begin
    mesh_result_t want;
    if (!rst_n) begin
      disp_scale = SCALE_RESET;
      for (int i = 0; i < 1024; i++) begin
        nrm_x_mem[i] = 0;
        nrm_y_mem[i] = 0;
        nrm_z_mem[i] = 0;
      end
      awaited_results.delete();
      err_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("%0t: result transfer with nothing expected", $time);
        end else begin
          want = awaited_results.pop_front();
          if (want.skipped !== out_tuser[0]) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: status expected %0b got %0b", $time, want.skipped, out_tuser[0]);
          end
          for (int f = 0; f < 6; f++) begin
            if (want.fields[f*32 +: 32] !== out_tdata[f*32 +: 32]) begin
              err_count++;
              if (err_count <= 10)
                $display("%0t: field %0d (pos x,y,z then norm x,y,z) expected %h got %h",
                         $time, f, want.fields[f*32 +: 32], out_tdata[f*32 +: 32]);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        awaited_results = {awaited_results, predict_result(in_tuser, in_tdata)};
      if (cfg_wr_en) disp_scale = cfg_wr_data;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Testbench top for deformed_mesh_vertex_normals: clock, reset, stimulus and verdict.
// Depends on dmvn_pkg, the block and dmvn_checker, which does all predicting.
`timescale 1ns / 1ps

module testbench;
  import dmvn_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [231:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_wr_en;
  logic [23:0]  cfg_wr_data;
  int           mismatches;
  int           pending;
  int           items_sent;
  bit           all_done;
  bit           loaded [1024];
  int           loaded_list [$];

  deformed_mesh_vertex_normals dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  dmvn_checker mesh_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver: sparse random stalls, one long hold-off, one quiet window
  initial begin
    int cyc;
    int hold_left;
    cyc = 0;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 20000) hold_left = 700;
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = (cyc > 40000 && cyc < 52000) || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || all_done)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [231:0] pack_item(int vi, logic [31:0] rx, logic [31:0] ry,
                                             logic [31:0] rz, logic [31:0] dx,
                                             logic [31:0] dy, logic [31:0] dz,
                                             int a, int b, int c);
    return {c[9:0], b[9:0], a[9:0], dz, dy, dx, rz, ry, rx, vi[9:0]};
  endfunction

  // Q16.16 value drawn from mixed magnitudes
  function automatic logic [31:0] rand_coord(int wide_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < wide_pct) return $urandom();
    if (pick < wide_pct + 5) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (pick < 60) return $urandom() >>> 8 ^ ($urandom_range(0, 1) ? 32'hFF00_0000 : 0);
    return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
  endfunction

  task automatic send_item(cmd_code_t kind, logic [231:0] data);
    int gap;
    if (!(items_sent > 700 && items_sent < 820) && $urandom_range(0, 99) < 6) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (kind == CMD_LOAD && !loaded[data[9:0]]) begin
      loaded[data[9:0]] = 1'b1;
      loaded_list = {loaded_list, int'(data[9:0])};
    end
  endtask

  task automatic load_vertex(int vi, logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                             logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    send_item(CMD_LOAD, pack_item(vi, rx, ry, rz, dx, dy, dz, $urandom_range(0, 1023),
                                  $urandom_range(0, 1023), $urandom_range(0, 1023)));
  endtask

  task automatic triangle(int a, int b, int c);
    send_item(CMD_TRI, pack_item($urandom_range(0, 1023), $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom(), a, b, c));
  endtask

  task automatic read_vertex(int vi);
    send_item(CMD_READ, pack_item(vi, $urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom(), $urandom_range(0, 1023),
                                  $urandom_range(0, 1023), $urandom_range(0, 1023)));
  endtask

  // write the scale once every result is in and the block has drained
  task automatic set_scale(logic [23:0] value);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic random_phase(int count);
    int pick;
    int a, b, c;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 28 || loaded_list.size() < 3) begin
        load_vertex($urandom_range(0, 1023), rand_coord(15), rand_coord(15), rand_coord(15),
                    rand_coord(5), rand_coord(5), rand_coord(5));
      end else if (pick < 75) begin
        a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        c = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        // occasionally repeat a corner to make a degenerate face
        if ($urandom_range(0, 99) < 8) c = a;
        triangle(a, b, c);
      end else if (pick < 95) begin
        read_vertex(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
      end else begin
        send_item(CMD_NONE, 232'({$urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom(), $urandom(), $urandom()}));
      end
    end
  endtask

  initial begin
    items_sent  = 0;
    all_done    = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_LOAD;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, unit faces, degenerate faces, normal cleared by reload
    load_vertex(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    load_vertex(1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h0);
    load_vertex(1, 0, 0, 0, 0, 0, 0);
    load_vertex(2, 32'h0001_0000, 0, 0, 0, 0, 0);
    load_vertex(3, 0, 32'h0001_0000, 0, 0, 0, 0);
    load_vertex(4, 32'h0002_0000, 0, 0, 0, 0, 0);
    load_vertex(5, 0, 0, 0, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001);
    triangle(1, 2, 3);
    triangle(0, 1023, 1);
    triangle(1023, 0, 3);
    triangle(1, 1, 2);
    triangle(1, 2, 4);
    triangle(2, 2, 2);
    read_vertex(0);
    read_vertex(1023);
    read_vertex(1);
    read_vertex(2);
    read_vertex(5);
    load_vertex(2, 32'h0001_0000, 0, 0, 0, 0, 0);
    read_vertex(2);
    send_item(CMD_NONE, '1);

    // random phases across scale settings, extremes included
    random_phase(260);
    set_scale(24'd0);
    random_phase(260);
    set_scale(24'hFF_FFFF);
    random_phase(260);
    set_scale(24'd1);
    random_phase(260);
    set_scale(24'($urandom_range(0, 24'hFF_FFFF)));
    random_phase(270);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    all_done = 1'b1;
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
